FILE: sv/ttop_pkg.sv
// ----------------------------------------------------------------------------
// ttop_pkg: timer table shared definitions
// Widths, opcode and result codes, controller states and the types that
// travel between the controller and the row of table cells.
// ----------------------------------------------------------------------------
package ttop_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

    localparam int OP_W    = 2;
    localparam int TIME_W  = 40;
    localparam int DUE_W   = 41;
    localparam int DELAY_W = 32;
    localparam int ID_W    = 32;
    localparam int WAIT_W  = 16;
    localparam int KIND_W  = 3;

    localparam logic [WAIT_W-1:0] WAIT_CAP_RESET = WAIT_W'(250);
    localparam logic [ID_W-1:0]   FIRST_ID       = ID_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET_DONE   = 3'd0,
        KIND_CLEAR_DONE = 3'd1,
        KIND_FIRED      = 3'd2,
        KIND_TICK_DONE  = 3'd3,
        KIND_FULL       = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_CLEAR,
        ST_TICK,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [DUE_W-1:0]   due;
        logic [DELAY_W-1:0] interval;
        logic               periodic;
    } entry_t;

    // table update issued by the controller for one cycle
    typedef struct packed {
        logic              remove_en;
        logic [SLOT_W-1:0] remove_idx;
        logic              load_en;
        logic [SLOT_W-1:0] load_idx;
        entry_t            load_entry;
    } table_cmd_t;

    // per-cell decode of a table update
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

FILE: sv/timer_table_one_shot_periodic_core.sv
// ----------------------------------------------------------------------------
// timer_table_one_shot_periodic_core: table of one-shot and periodic timers
// Set, clear and tick words over a row of timer slots with a registered
// result stage.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready): one word per operation: set a timer
//     (next id, due at now plus delay), clear a timer by id, or tick at now
//   output channel (out_valid / out_ready): result words; set gives one
//     (set done or table full), clear gives one, tick gives one word per
//     fired timer in table order and then a tick done word with the wait
//     until the earliest remaining due time, capped at the wait cap register
//   cfg_we / cfg_wdata: writes the wait cap; the user writes it only while the
//     block is idle, which the block itself does not enforce
// timing
//   the sequencer takes one word at a time; in_ready is high only when idle
//   clear scans to the matching id or the table end; tick scans every slot,
//   one slot per cycle through the scan pointer, stalled by a refused result;
//   a result is registered and shows in the cycle after the sequencer emits it
// reset
//   empty table, next id 1, wait cap 250, no result pending
// stall
//   a full result register stops the scan on the next fired timer or final
//   word and holds back a set result; no word is dropped
// ----------------------------------------------------------------------------
module timer_table_one_shot_periodic_core
    import ttop_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    opcode,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic [DELAY_W-1:0] delay_ms,
    input  logic               periodic,
    input  logic [ID_W-1:0]    timer_id,
    input  logic               cfg_we,
    input  logic [WAIT_W-1:0]  cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  kind,
    output logic [ID_W-1:0]    timer_id_res,
    output logic [WAIT_W-1:0]  wait_ms,
    output logic               last
);

    entry_t           slot_q [TIMER_SLOTS];
    cell_ctrl_t       cell_ctrl [TIMER_SLOTS];
    table_cmd_t       cmd;
    logic [CNT_W-1:0] fill_count;

    // sequencer and result register
    ttop_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .now_ms       (now_ms),
        .delay_ms     (delay_ms),
        .periodic     (periodic),
        .timer_id     (timer_id),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .timer_id_res (timer_id_res),
        .wait_ms      (wait_ms),
        .last         (last),
        .slot_q       (slot_q),
        .cmd          (cmd),
        .fill_count   (fill_count)
    );

    // row of slots: valid entries always sit in the lowest slots, in
    // insertion order; a removal makes every slot at or above it take its
    // upper neighbor's entry
    for (genvar j = 0; j < TIMER_SLOTS; j++)
    begin : g_slot
        entry_t upper;

        assign cell_ctrl[j].shift = cmd.remove_en && (SLOT_W'(j) >= cmd.remove_idx);
        assign cell_ctrl[j].load  = cmd.load_en && (cmd.load_idx == SLOT_W'(j));

        if (j == TIMER_SLOTS - 1)
        begin : g_top
            // top slot falls out of the table on a removal
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = slot_q[j + 1];
        end

        ttop_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[j]),
            .from_next (upper),
            .load_data (cmd.load_entry),
            .entry     (slot_q[j])
        );
    end

    // table fill never runs past the number of slots
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count <= CNT_W'(TIMER_SLOTS))
        else $error("table fill count out of range");

    // a slot is never loaded and compacted in the same cycle
    a_no_load_and_remove: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.remove_en && cmd.load_en))
        else $error("load and removal issued together");

    // removals only hit occupied slots
    a_remove_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove_en |-> (CNT_W'(cmd.remove_idx) < fill_count))
        else $error("removal of an empty slot");

    // a real operation keeps the input closed while it runs
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode != OP_NONE)) |=> !in_ready)
        else $error("input open while an operation runs");

endmodule

FILE: sv/ttop_cell.sv
// ----------------------------------------------------------------------------
// ttop_cell: one timer table slot
// Holds one entry; loads a new entry from the controller or takes the entry
// of the next slot up when it or an earlier slot is removed.
// ----------------------------------------------------------------------------
module ttop_cell
    import ttop_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     from_next,
    input  entry_t     load_data,
    output entry_t     entry
);

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= load_data;
        end
        else if (ctrl.shift)
        begin
            entry_reg <= from_next;
        end
    end

    assign entry = entry_reg;

endmodule

FILE: sv/ttop_ctrl.sv
// ----------------------------------------------------------------------------
// ttop_ctrl: timer table sequencer
// Takes one word, walks the table slot by slot, issues loads and removals to
// the cells and fills the registered result stage.
// ----------------------------------------------------------------------------
module ttop_ctrl
    import ttop_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    opcode,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic [DELAY_W-1:0] delay_ms,
    input  logic               periodic,
    input  logic [ID_W-1:0]    timer_id,
    input  logic               cfg_we,
    input  logic [WAIT_W-1:0]  cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  kind,
    output logic [ID_W-1:0]    timer_id_res,
    output logic [WAIT_W-1:0]  wait_ms,
    output logic               last,
    input  entry_t             slot_q [TIMER_SLOTS],
    output table_cmd_t         cmd,
    output logic [CNT_W-1:0]   fill_count
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic [WAIT_W-1:0]  cap_reg;
    logic [WAIT_W-1:0]  best_reg, best_next;
    opcode_t            op_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               per_reg;
    logic [ID_W-1:0]    cid_reg;
    logic               latch_en;

    logic               out_valid_reg, out_valid_next;
    kind_t              kind_reg;
    logic [ID_W-1:0]    id_res_reg;
    logic [WAIT_W-1:0]  wait_reg;
    logic               last_reg;

    logic               emit;
    kind_t              emit_kind;
    logic [ID_W-1:0]    emit_id;
    logic [WAIT_W-1:0]  emit_wait;
    logic               emit_last;

    entry_t             head;
    logic [DUE_W:0]     diff;
    logic               fire;
    logic [WAIT_W-1:0]  pending_wait;
    logic [DUE_W-1:0]   rearm_due;
    logic [WAIT_W-1:0]  rearm_wait;
    logic               out_free;
    logic               ptr_at_end;

    // slot under the scan pointer
    assign head = slot_q[ptr_reg[SLOT_W-1:0]];

    // due - now; negative or zero means the timer is due
    assign diff = {1'b0, head.due} - {{(DUE_W - TIME_W + 1){1'b0}}, now_reg};
    assign fire = diff[DUE_W] || (diff == '0);
    assign pending_wait = (diff[DUE_W-1:WAIT_W] != '0) ? '1 : diff[WAIT_W-1:0];

    assign rearm_due  = {{(DUE_W - TIME_W){1'b0}}, now_reg} + DUE_W'(head.interval);
    assign rearm_wait = (head.interval[DELAY_W-1:WAIT_W] != '0) ? '1
                                                               : head.interval[WAIT_W-1:0];

    assign out_free   = !out_valid_reg || out_ready;
    assign ptr_at_end = (ptr_reg >= count_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        next_id_next = next_id_reg;
        best_next    = best_reg;
        latch_en     = 1'b0;
        in_ready     = 1'b0;
        cmd          = '0;
        emit         = 1'b0;
        emit_kind    = KIND_SET_DONE;
        emit_id      = '0;
        emit_wait    = '0;
        emit_last    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    latch_en  = 1'b1;
                    ptr_next  = '0;
                    best_next = cap_reg;
                    case (opcode_t'(opcode))
                        OP_SET:   state_next = ST_SET;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_TICK:  state_next = ST_TICK;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end

            ST_SET:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    if (count_reg == CNT_W'(TIMER_SLOTS))
                    begin
                        emit_kind = KIND_FULL;
                    end
                    else
                    begin
                        cmd.load_en             = 1'b1;
                        cmd.load_idx            = count_reg[SLOT_W-1:0];
                        cmd.load_entry.id       = next_id_reg;
                        cmd.load_entry.due      = {{(DUE_W - TIME_W){1'b0}}, now_reg}
                                                  + DUE_W'(delay_reg);
                        cmd.load_entry.interval = delay_reg;
                        cmd.load_entry.periodic = per_reg;
                        count_next              = count_reg + CNT_W'(1);
                        next_id_next            = next_id_reg + ID_W'(1);
                        emit_kind               = KIND_SET_DONE;
                        emit_id                 = next_id_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_CLEAR:
            begin
                if (ptr_at_end)
                begin
                    state_next = ST_FINAL;
                end
                else if (head.id == cid_reg)
                begin
                    cmd.remove_en  = 1'b1;
                    cmd.remove_idx = ptr_reg[SLOT_W-1:0];
                    count_next     = count_reg - CNT_W'(1);
                    state_next     = ST_FINAL;
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end

            ST_TICK:
            begin
                if (ptr_at_end)
                begin
                    state_next = ST_FINAL;
                end
                else if (fire)
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_FIRED;
                        emit_id   = head.id;
                        if (head.periodic)
                        begin
                            cmd.load_en             = 1'b1;
                            cmd.load_idx            = ptr_reg[SLOT_W-1:0];
                            cmd.load_entry.id       = head.id;
                            cmd.load_entry.due      = rearm_due;
                            cmd.load_entry.interval = head.interval;
                            cmd.load_entry.periodic = 1'b1;
                            ptr_next                = ptr_reg + CNT_W'(1);
                            if (rearm_wait < best_reg)
                            begin
                                best_next = rearm_wait;
                            end
                        end
                        else
                        begin
                            // later slots move down, pointer stays
                            cmd.remove_en  = 1'b1;
                            cmd.remove_idx = ptr_reg[SLOT_W-1:0];
                            count_next     = count_reg - CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                    if (pending_wait < best_reg)
                    begin
                        best_next = pending_wait;
                    end
                end
            end

            ST_FINAL:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    if (op_reg == OP_TICK)
                    begin
                        emit_kind = KIND_TICK_DONE;
                        emit_wait = best_reg;
                    end
                    else
                    begin
                        emit_kind = KIND_CLEAR_DONE;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            next_id_reg   <= FIRST_ID;
            cap_reg       <= WAIT_CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        if (latch_en)
        begin
            op_reg    <= opcode_t'(opcode);
            now_reg   <= now_ms;
            delay_reg <= delay_ms;
            per_reg   <= periodic;
            cid_reg   <= timer_id;
        end
        if (emit)
        begin
            kind_reg   <= emit_kind;
            id_res_reg <= emit_id;
            wait_reg   <= emit_wait;
            last_reg   <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = KIND_W'(kind_reg);
    assign timer_id_res = id_res_reg;
    assign wait_ms      = wait_reg;
    assign last         = last_reg;
    assign fill_count   = count_reg;

endmodule
